### hdl/pckd_pkg.sv
// pckd_pkg: shared types, widths and scale tables of the pitch-class key detector
// depends on nothing; used by pckd_accum, pckd_score and pitch_class_key_detector

package pckd_pkg;

  // field widths
  localparam int PitchBits = 7;
  localparam int RootBits  = 4;
  localparam int ScoreBits = 16;
  localparam int NotesBits = 16;
  localparam int TotalBits = 23;

  // histogram geometry
  localparam int CountBits  = 16;
  localparam int NumClasses = 12;
  localparam int NumDegrees = 7;
  localparam int SumBits    = CountBits + 3;
  localparam int NumKeys    = 2 * NumClasses;
  localparam int GroupSize  = 4;
  localparam int NumGroups  = NumKeys / GroupSize;

  // pitch mod 12 by reciprocal: floor(p / 12) == (p * 43) >> 9 for p < 128
  localparam int PcRecip   = 43;
  localparam int PcShift   = 9;
  localparam int PcProdBits = PitchBits + 6;

  // reset values of the pitch range trackers
  localparam logic [PitchBits-1:0] LowestInit  = '1;
  localparam logic [PitchBits-1:0] HighestInit = '0;

  typedef logic [NumClasses-1:0][CountBits-1:0] counts_t;
  typedef logic [NumKeys-1:0][SumBits-1:0]      sums_t;

  typedef struct packed {
    logic [NotesBits-1:0] note_count;
    logic [TotalBits-1:0] pitch_total;
    logic [PitchBits-1:0] lowest_pitch;
    logic [PitchBits-1:0] highest_pitch;
  } stats_t;

  typedef struct packed {
    logic                is_minor;
    logic [RootBits-1:0] root;
  } key_t;

  // scale degree offsets, major then natural minor
  function automatic int scale_step(input bit minor, input int degree);
    int major_tab [NumDegrees];
    int minor_tab [NumDegrees];
    major_tab = '{0, 2, 4, 5, 7, 9, 11};
    minor_tab = '{0, 2, 3, 5, 7, 8, 10};
    return minor ? minor_tab[degree] : major_tab[degree];
  endfunction

  // pitch class of one scale degree of a key
  function automatic int class_index(input int root, input bit minor, input int degree);
    return (root + scale_step(minor, degree)) % NumClasses;
  endfunction

  // key order: major C..B, then minor C..B
  function automatic key_t key_of(input int k);
    key_t key;
    key.is_minor = (k >= NumClasses);
    key.root     = RootBits'(k % NumClasses);
    return key;
  endfunction

endpackage

### hdl/pckd_accum.sv
// pckd_accum: input register, pitch-class histogram and piece statistics
// hands a snapshot of the finished piece to pckd_score; uses pckd_pkg

module pckd_accum (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pckd_pkg::PitchBits-1:0]  in_pitch,
  input  logic                            in_last,
  input  logic                            snap_ready,
  output logic                            snap_valid,
  output pckd_pkg::counts_t               snap_counts,
  output pckd_pkg::stats_t                snap_stats
);

  logic                           s0_valid_r;
  logic [pckd_pkg::PitchBits-1:0] s0_pitch_r;
  logic                           s0_last_r;

  pckd_pkg::counts_t              counts_r;
  pckd_pkg::counts_t              counts_nxt;
  pckd_pkg::stats_t               stats_r;
  pckd_pkg::stats_t               stats_nxt;

  logic                           snap_valid_r;
  pckd_pkg::counts_t              snap_counts_r;
  pckd_pkg::stats_t               snap_stats_r;

  logic                              snap_free;
  logic                              s0_ready;
  logic                              s0_fire;
  logic [pckd_pkg::PcProdBits-1:0]   pc_prod;
  logic [pckd_pkg::RootBits-1:0]     pc_quot;
  logic [pckd_pkg::PitchBits-1:0]    pc_rem;
  logic [pckd_pkg::RootBits-1:0]     pitch_class;
  logic [pckd_pkg::TotalBits:0]      total_sum;

  // handshake: a last note waits for the snapshot slot, other notes never wait
  assign snap_free = !snap_valid_r || snap_ready;
  assign s0_ready  = !s0_valid_r || !s0_last_r || snap_free;
  assign s0_fire   = s0_valid_r && s0_ready;
  assign in_stall  = !s0_ready;

  // pitch class by reciprocal multiply
  assign pc_prod     = pckd_pkg::PcProdBits'(s0_pitch_r)
                     * pckd_pkg::PcProdBits'(pckd_pkg::PcRecip);
  assign pc_quot     = pc_prod[pckd_pkg::PcProdBits-1:pckd_pkg::PcShift];
  assign pc_rem      = s0_pitch_r - pckd_pkg::PitchBits'(pc_quot)
                     * pckd_pkg::PitchBits'(pckd_pkg::NumClasses);
  assign pitch_class = pc_rem[pckd_pkg::RootBits-1:0];

  assign total_sum = {1'b0, stats_r.pitch_total} + (pckd_pkg::TotalBits + 1)'(s0_pitch_r);

  // updated histogram and statistics, this note included
  always_comb begin
    counts_nxt = counts_r;
    for (int i = 0; i < pckd_pkg::NumClasses; i++) begin
      if (pitch_class == pckd_pkg::RootBits'(i) && !(&counts_r[i])) begin
        counts_nxt[i] = counts_r[i] + 1'b1;
      end
    end
    stats_nxt = stats_r;
    if (!(&stats_r.note_count)) begin
      stats_nxt.note_count = stats_r.note_count + 1'b1;
    end
    stats_nxt.pitch_total = total_sum[pckd_pkg::TotalBits] ? '1
                          : total_sum[pckd_pkg::TotalBits-1:0];
    if (s0_pitch_r < stats_r.lowest_pitch) begin
      stats_nxt.lowest_pitch = s0_pitch_r;
    end
    if (s0_pitch_r > stats_r.highest_pitch) begin
      stats_nxt.highest_pitch = s0_pitch_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_r <= in_valid;
    end
    if (s0_ready) begin
      s0_pitch_r <= in_pitch;
      s0_last_r  <= in_last;
    end
  end

  // piece state, cleared after the last note
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counts_r                <= '0;
      stats_r.note_count      <= '0;
      stats_r.pitch_total     <= '0;
      stats_r.lowest_pitch    <= pckd_pkg::LowestInit;
      stats_r.highest_pitch   <= pckd_pkg::HighestInit;
    end else if (s0_fire) begin
      if (s0_last_r) begin
        counts_r              <= '0;
        stats_r.note_count    <= '0;
        stats_r.pitch_total   <= '0;
        stats_r.lowest_pitch  <= pckd_pkg::LowestInit;
        stats_r.highest_pitch <= pckd_pkg::HighestInit;
      end else begin
        counts_r <= counts_nxt;
        stats_r  <= stats_nxt;
      end
    end
  end

  // snapshot of the finished piece
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (snap_free) begin
      snap_valid_r <= s0_fire && s0_last_r;
    end
    if (snap_free && s0_fire && s0_last_r) begin
      snap_counts_r <= counts_nxt;
      snap_stats_r  <= stats_nxt;
    end
  end

  assign snap_valid  = snap_valid_r;
  assign snap_counts = snap_counts_r;
  assign snap_stats  = snap_stats_r;

endmodule

### hdl/pckd_score.sv
// pckd_score: key scoring of a finished piece and the result register
// three stages: key sums, group winners, final winner; uses pckd_pkg

module pckd_score (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            snap_valid,
  output logic                            snap_ready,
  input  pckd_pkg::counts_t               snap_counts,
  input  pckd_pkg::stats_t                snap_stats,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pckd_pkg::RootBits-1:0]   out_key_root,
  output logic                            out_is_minor,
  output logic [pckd_pkg::ScoreBits-1:0]  out_key_score,
  output logic [pckd_pkg::NotesBits-1:0]  out_note_count,
  output logic [pckd_pkg::TotalBits-1:0]  out_pitch_total,
  output logic [pckd_pkg::PitchBits-1:0]  out_lowest_pitch,
  output logic [pckd_pkg::PitchBits-1:0]  out_highest_pitch
);

  logic                                           sum_valid_r;
  pckd_pkg::sums_t                                sums_r;
  pckd_pkg::sums_t                                sums_nxt;
  pckd_pkg::stats_t                               sum_stats_r;

  logic                                           grp_valid_r;
  logic [pckd_pkg::NumGroups-1:0][pckd_pkg::SumBits-1:0] grp_score_r;
  logic [pckd_pkg::NumGroups-1:0][pckd_pkg::SumBits-1:0] grp_score_nxt;
  pckd_pkg::key_t [pckd_pkg::NumGroups-1:0]       grp_key_r;
  pckd_pkg::key_t [pckd_pkg::NumGroups-1:0]       grp_key_nxt;
  pckd_pkg::stats_t                               grp_stats_r;

  logic                                           out_valid_r;
  pckd_pkg::key_t                                 out_key_r;
  pckd_pkg::key_t                                 win_key;
  logic [pckd_pkg::SumBits-1:0]                   win_score;
  logic [pckd_pkg::ScoreBits-1:0]                 out_score_r;
  logic [pckd_pkg::ScoreBits-1:0]                 score_nxt;
  logic [pckd_pkg::SumBits+pckd_pkg::ScoreBits-1:0] score_wide;
  pckd_pkg::stats_t                               out_stats_r;

  logic out_free;
  logic grp_free;
  logic sum_free;

  // stage-by-stage flow control
  assign out_free   = !out_valid_r || !out_stall;
  assign grp_free   = !grp_valid_r || out_free;
  assign sum_free   = !sum_valid_r || grp_free;
  assign snap_ready = sum_free;

  // seven-degree sum of every key
  always_comb begin
    for (int k = 0; k < pckd_pkg::NumKeys; k++) begin
      sums_nxt[k] = '0;
      for (int d = 0; d < pckd_pkg::NumDegrees; d++) begin
        sums_nxt[k] = sums_nxt[k] + pckd_pkg::SumBits'(snap_counts[pckd_pkg::class_index(
                        k % pckd_pkg::NumClasses, k >= pckd_pkg::NumClasses, d)]);
      end
    end
  end

  // winner of each group of keys; a later key must be strictly greater
  always_comb begin
    for (int g = 0; g < pckd_pkg::NumGroups; g++) begin
      grp_score_nxt[g] = sums_r[g * pckd_pkg::GroupSize];
      grp_key_nxt[g]   = pckd_pkg::key_of(g * pckd_pkg::GroupSize);
      for (int j = 1; j < pckd_pkg::GroupSize; j++) begin
        if (sums_r[g * pckd_pkg::GroupSize + j] > grp_score_nxt[g]) begin
          grp_score_nxt[g] = sums_r[g * pckd_pkg::GroupSize + j];
          grp_key_nxt[g]   = pckd_pkg::key_of(g * pckd_pkg::GroupSize + j);
        end
      end
    end
  end

  // final winner over the groups, in key order
  always_comb begin
    win_score = grp_score_r[0];
    win_key   = grp_key_r[0];
    for (int g = 1; g < pckd_pkg::NumGroups; g++) begin
      if (grp_score_r[g] > win_score) begin
        win_score = grp_score_r[g];
        win_key   = grp_key_r[g];
      end
    end
  end

  // saturate the winning score to the output width
  assign score_wide = (pckd_pkg::SumBits + pckd_pkg::ScoreBits)'(win_score);
  assign score_nxt  = (score_wide > (pckd_pkg::SumBits + pckd_pkg::ScoreBits)'({pckd_pkg::ScoreBits{1'b1}}))
                    ? '1 : score_wide[pckd_pkg::ScoreBits-1:0];

  // key sum stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
    end else if (sum_free) begin
      sum_valid_r <= snap_valid;
    end
    if (sum_free && snap_valid) begin
      sums_r      <= sums_nxt;
      sum_stats_r <= snap_stats;
    end
  end

  // group winner stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
    end else if (grp_free) begin
      grp_valid_r <= sum_valid_r;
    end
    if (grp_free && sum_valid_r) begin
      grp_score_r <= grp_score_nxt;
      grp_key_r   <= grp_key_nxt;
      grp_stats_r <= sum_stats_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= grp_valid_r;
    end
    if (out_free && grp_valid_r) begin
      out_key_r   <= win_key;
      out_score_r <= score_nxt;
      out_stats_r <= grp_stats_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_key_root      = out_key_r.root;
  assign out_is_minor      = out_key_r.is_minor;
  assign out_key_score     = out_score_r;
  assign out_note_count    = out_stats_r.note_count;
  assign out_pitch_total   = out_stats_r.pitch_total;
  assign out_lowest_pitch  = out_stats_r.lowest_pitch;
  assign out_highest_pitch = out_stats_r.highest_pitch;

endmodule

### hdl/pitch_class_key_detector.sv
// pitch_class_key_detector: top level of the pitch-class key detector
// instantiates pckd_accum and pckd_score; uses pckd_pkg

// Takes one MIDI note per word and builds a 12-bin pitch-class histogram with
// saturating counters, plus note count, pitch sum and pitch range. A note with
// last set is counted, then the piece is scored against the 12 major and 12
// natural-minor keys (earliest key wins a tie: major C..B, then minor C..B)
// and one result word comes out; the histogram and statistics then restart
// from their reset values. A note is taken every cycle, last notes included,
// as long as the result side keeps up; a last note waits while the scoring
// stages are full. Notes without last never wait once the input register is
// free. Once the last note is accepted, the result passes the input register,
// the histogram snapshot, the key sums, the group winners of four keys each
// and the final winner in the output register. Notes without last give no
// result word.

module pitch_class_key_detector (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pckd_pkg::PitchBits-1:0]  in_pitch,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pckd_pkg::RootBits-1:0]   out_key_root,
  output logic                            out_is_minor,
  output logic [pckd_pkg::ScoreBits-1:0]  out_key_score,
  output logic [pckd_pkg::NotesBits-1:0]  out_note_count,
  output logic [pckd_pkg::TotalBits-1:0]  out_pitch_total,
  output logic [pckd_pkg::PitchBits-1:0]  out_lowest_pitch,
  output logic [pckd_pkg::PitchBits-1:0]  out_highest_pitch
);

  logic              snap_valid;
  logic              snap_ready;
  pckd_pkg::counts_t snap_counts;
  pckd_pkg::stats_t  snap_stats;

  // histogram and statistics
  pckd_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pitch    (in_pitch),
    .in_last     (in_last),
    .snap_ready  (snap_ready),
    .snap_valid  (snap_valid),
    .snap_counts (snap_counts),
    .snap_stats  (snap_stats)
  );

  // key scoring and result register
  pckd_score u_score (
    .clk               (clk),
    .rst_n             (rst_n),
    .snap_valid        (snap_valid),
    .snap_ready        (snap_ready),
    .snap_counts       (snap_counts),
    .snap_stats        (snap_stats),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_key_root      (out_key_root),
    .out_is_minor      (out_is_minor),
    .out_key_score     (out_key_score),
    .out_note_count    (out_note_count),
    .out_pitch_total   (out_pitch_total),
    .out_lowest_pitch  (out_lowest_pitch),
    .out_highest_pitch (out_highest_pitch)
  );

endmodule
